### src/lpc_pkg.sv
// Package for the lemniscate pursuit controller: widths, constants, tables and state codes.
`default_nettype none
package lpc_pkg;
	localparam int CordicIterations = 18;
	localparam int CntW = 5;
	localparam logic [19:0] PiQ16 = 20'd205887;
	localparam logic [19:0] TwoPiQ16 = 20'd411775;
	localparam logic [19:0] HalfPiQ16 = 20'd102944;
	localparam logic signed [35:0] PiQ30 = 36'sd3373259426;
	localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
	localparam logic signed [35:0] GainQ30 = 36'sd652032874;
	localparam logic [1:0] RegCurveSize = 2'd0;
	localparam logic [1:0] RegPhaseStep = 2'd1;
	localparam logic [1:0] RegRateGain = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PREP, ST_ROT, ST_DEN, ST_MULX, ST_MULY, ST_DIVX, ST_DIVY,
		ST_ERR, ST_VEC, ST_SQ1, ST_SQ2, ST_SQRT, ST_OUT1, ST_OUT2, ST_DONE
	} state_t;

	function automatic logic signed [35:0] atan_q30(input logic [CntW-1:0] i);
		logic signed [35:0] r;
		unique case (i)
			5'd0: r = 36'sh03243F6A8; 5'd1: r = 36'sh01DAC6705;
			5'd2: r = 36'sh00FADBAFC; 5'd3: r = 36'sh007F56EA6;
			5'd4: r = 36'sh003FEAB76; 5'd5: r = 36'sh001FFD55B;
			5'd6: r = 36'sh000FFFAAA; 5'd7: r = 36'sh0007FFF55;
			5'd8: r = 36'sh0003FFFEA; 5'd9: r = 36'sh0001FFFFD;
			5'd10: r = 36'sh0000FFFFF; 5'd11: r = 36'sh00007FFFF;
			5'd12: r = 36'sh00003FFFF; 5'd13: r = 36'sh00001FFFF;
			5'd14: r = 36'sh00000FFFF; 5'd15: r = 36'sh000007FFF;
			5'd16: r = 36'sh000003FFF; 5'd17: r = 36'sh000001FFF;
			5'd18: r = 36'sh000000FFF; 5'd19: r = 36'sh0000007FF;
			5'd20: r = 36'sh0000003FF; 5'd21: r = 36'sh0000001FF;
			5'd22: r = 36'sh0000000FF; 5'd23: r = 36'sh00000007F;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

### src/lemniscate_pursuit_controller.sv
// Top level of the lemniscate pursuit controller: sequencer with shared CORDIC, divider and root.
//
// Channel  Direction  Word
// s_axis   in         tdata = pose_x[23:0], pose_y[47:24], pose_heading[66:48], zero to 72
// m_axis   out        tdata = linear_speed[30:0], angular_speed[62:31], zero to 64
// cfg      in         we, idx (0 curve_size, 1 phase_step, 2 rate_gain), wdata[21:0]
//
// One word passes through an 18-step rotation CORDIC, two 64-step restoring divisions, an
// 18-step vectoring CORDIC and a 32-step square root, each one step a cycle, with setup
// states before each, run on one shared datapath. s_axis_tready is high only in the idle
// state. The result waits in the output register while the next word is computed; the
// sequencer holds in its output state ST_OUT2 only if the previous result has still not
// been taken.
// Reset is asynchronous, clears the control state and curve origin and presets config and phase.
`default_nettype none
module lemniscate_pursuit_controller (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [71:0] s_axis_tdata,  // pose_x, pose_y, pose_heading
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,  // linear_speed, angular_speed
	input  wire logic        we,
	input  wire logic [1:0]  idx,
	input  wire logic [21:0] wdata
);
	import lpc_pkg::*;

	state_t state_q, state_d;
	logic [21:0] curve_size_q;
	logic [16:0] phase_step_q;
	logic [9:0]  rate_gain_q;
	logic [19:0] phase_q;
	logic signed [23:0] origin_x_q, origin_y_q;
	logic latched_q;
	logic signed [23:0] px_q, py_q;
	logic signed [18:0] th_q;
	logic [CntW:0] cnt_q;
	logic flip_q;
	// CORDIC registers shared by both modes
	logic signed [63:0] x_q, y_q;
	logic signed [35:0] z_q, base_q;
	logic zero_q;
	// Product and division registers
	logic [63:0] rem_q, quo_q;
	logic [35:0] den_q;
	logic neg_q;
	logic signed [35:0] s_q, c_q, scs_q;
	logic signed [35:0] ex_q, ey_q, dx_q;
	logic signed [35:0] err_q;
	logic [31:0] dist_q;
	logic [63:0] sqv_q, sqr_q, sqb_q;
	logic [30:0] lin_q;
	logic signed [31:0] rot_q;
	logic out_v_q;

	logic [CntW-1:0] ci;
	logic signed [63:0] xs, ys;
	logic [20:0] ph_sum;
	logic [19:0] ph_new;
	logic signed [35:0] ang16, ang30;
	logic signed [63:0] mul_w;
	logic [99:0] sub_try;
	logic signed [35:0] ex_w, ey_w;
	logic signed [35:0] bear;
	logic signed [35:0] err_raw;
	logic signed [47:0] lin_w, rot_w;
	logic start;
	logic out_load;

	assign ci = cnt_q[CntW-1:0];
	assign xs = x_q >>> ci;
	assign ys = y_q >>> ci;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign start = s_axis_tvalid && s_axis_tready;
	assign out_load = (state_q == ST_OUT2) && (!out_v_q || m_axis_tready);
	assign ph_sum = {1'b0, phase_q} + {4'd0, phase_step_q};
	assign ph_new = (ph_sum >= {1'b0, TwoPiQ16}) ? 20'(ph_sum - {1'b0, TwoPiQ16})
		: ph_sum[19:0];
	assign ang16 = (phase_q > PiQ16) ? $signed({16'd0, phase_q}) - $signed({16'd0, TwoPiQ16})
		: $signed({16'd0, phase_q});
	assign ang30 = ang16 <<< 14;
	assign mul_w = 64'($signed({1'b0, curve_size_q}))
		* ((state_q == ST_MULX) ? 64'(c_q) : 64'(scs_q));
	assign sub_try = {36'd0, rem_q[62:0], quo_q[63]} - {64'd0, den_q};
	assign ex_w = 36'(origin_x_q) + dx_q - 36'(px_q);
	assign ey_w = 36'(origin_y_q) + (neg_q ? -$signed(36'(quo_q)) : $signed(36'(quo_q)))
		- 36'(py_q);
	assign bear = zero_q ? 36'sd0 : ((base_q + z_q + 36'sd8192) >>> 14);
	assign err_raw = bear - 36'(th_q);
	assign lin_w = $signed({16'd0, dist_q}) * $signed({38'd0, rate_gain_q});
	assign rot_w = 48'(err_q) * $signed({38'd0, rate_gain_q});
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {1'b0, rot_q, lin_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_PREP;
			ST_PREP: state_d = ST_ROT;
			ST_ROT: if (cnt_q == (CntW+1)'(CordicIterations - 1)) state_d = ST_DEN;
			ST_DEN: state_d = ST_MULX;
			ST_MULX: state_d = ST_DIVX;
			ST_DIVX: if (cnt_q == (CntW+1)'(63)) state_d = ST_MULY;
			ST_MULY: state_d = ST_DIVY;
			ST_DIVY: if (cnt_q == (CntW+1)'(63)) state_d = ST_ERR;
			ST_ERR: state_d = ST_VEC;
			ST_VEC: if (cnt_q == (CntW+1)'(CordicIterations - 1)) state_d = ST_SQ1;
			ST_SQ1: state_d = ST_SQ2;
			ST_SQ2: state_d = ST_SQRT;
			ST_SQRT: if (cnt_q == (CntW+1)'(31)) state_d = ST_OUT1;
			ST_OUT1: state_d = ST_OUT2;
			ST_OUT2: if (out_load) state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			curve_size_q <= 22'd262144;
			phase_step_q <= 17'd3277;
			rate_gain_q <= 10'd20;
			phase_q <= HalfPiQ16;
			origin_x_q <= '0;
			origin_y_q <= '0;
			latched_q <= 1'b0;
			out_v_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (we) begin
				unique case (idx)
					RegCurveSize: curve_size_q <= wdata;
					RegPhaseStep: phase_step_q <= wdata[16:0];
					RegRateGain: rate_gain_q <= wdata[9:0];
					default: ;
				endcase
			end
			out_v_q <= out_load || (out_v_q && !m_axis_tready);
			if (state_d != state_q) cnt_q <= '0;
			else cnt_q <= cnt_q + 1'b1;
			if (start) begin
				if (!latched_q) begin
					origin_x_q <= $signed(s_axis_tdata[23:0]);
					origin_y_q <= $signed(s_axis_tdata[47:24]);
					latched_q <= 1'b1;
				end
				phase_q <= ph_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (start) begin
				px_q <= $signed(s_axis_tdata[23:0]);
				py_q <= $signed(s_axis_tdata[47:24]);
				th_q <= $signed(s_axis_tdata[66:48]);
			end
			ST_PREP: begin
				// Fold the angle into [-pi/2, pi/2] and remember the half-turn.
				x_q <= 64'(GainQ30);
				y_q <= '0;
				if (ang30 > HalfPiQ30) begin
					z_q <= ang30 - PiQ30; flip_q <= 1'b1;
				end else if (ang30 < -HalfPiQ30) begin
					z_q <= ang30 + PiQ30; flip_q <= 1'b1;
				end else begin
					z_q <= ang30; flip_q <= 1'b0;
				end
			end
			ST_ROT, ST_VEC: begin
				if ((state_q == ST_ROT) ? !z_q[35] : y_q[63]) begin
					x_q <= x_q - ys; y_q <= y_q + xs;
					z_q <= (state_q == ST_ROT) ? z_q - atan_q30(ci) : z_q - atan_q30(ci);
				end else begin
					x_q <= x_q + ys; y_q <= y_q - xs;
					z_q <= z_q + atan_q30(ci);
				end
				if (state_q == ST_ROT && cnt_q == (CntW+1)'(CordicIterations - 1)) begin
					if (z_q[35]) begin
						s_q <= flip_q ? -36'(y_q - xs) : 36'(y_q - xs);
						c_q <= flip_q ? -36'(x_q + ys) : 36'(x_q + ys);
					end else begin
						s_q <= flip_q ? -36'(y_q + xs) : 36'(y_q + xs);
						c_q <= flip_q ? -36'(x_q - ys) : 36'(x_q - ys);
					end
				end
			end
			ST_DEN: begin
				den_q <= 36'((64'(s_q) * 64'(s_q)) >>> 30) + 36'd1073741824;
				scs_q <= 36'((64'(s_q) * 64'(c_q)) >>> 30);
			end
			ST_MULX, ST_MULY: begin
				neg_q <= mul_w[63];
				rem_q <= '0;
				quo_q <= mul_w[63] ? 64'(-mul_w) : 64'(mul_w);
				// The x quotient is complete here; keep it before the y division reuses quo_q.
				if (state_q == ST_MULY)
					dx_q <= neg_q ? -$signed(36'(quo_q)) : $signed(36'(quo_q));
			end
			ST_DIVX, ST_DIVY: begin
				// Restoring division of the magnitude, one quotient bit a cycle.
				if (!sub_try[99] && sub_try[63:0] < 64'h8000_0000_0000_0000) begin
					rem_q <= sub_try[63:0];
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= {rem_q[62:0], quo_q[63]};
					quo_q <= {quo_q[62:0], 1'b0};
				end
			end
			ST_ERR: begin
				ex_q <= ex_w;
				ey_q <= ey_w;
				z_q <= '0;
				zero_q <= (ex_w == '0) && (ey_w == '0);
				// A goal behind the robot is mirrored and its bearing starts from plus or minus pi.
				if (ex_w[35]) begin
					base_q <= ey_w[35] ? -PiQ30 : PiQ30;
					x_q <= -(64'(ex_w) <<< 16);
					y_q <= -(64'(ey_w) <<< 16);
				end else begin
					base_q <= '0;
					x_q <= 64'(ex_w) <<< 16;
					y_q <= 64'(ey_w) <<< 16;
				end
			end
			ST_SQ1: begin
				err_q <= '0;
				sqv_q <= 64'(64'(ex_q) * 64'(ex_q));
			end
			ST_SQ2: begin
				sqv_q <= sqv_q + 64'(64'(ey_q) * 64'(ey_q));
				sqr_q <= '0;
				sqb_q <= 64'h4000_0000_0000_0000;
				err_q <= (err_raw > $signed({16'd0, PiQ16})) ? err_raw - 36'(TwoPiQ16) : err_raw;
			end
			ST_SQRT: begin
				if (sqv_q >= sqr_q + sqb_q) begin
					sqv_q <= sqv_q - (sqr_q + sqb_q);
					sqr_q <= (sqr_q >> 1) + sqb_q;
				end else sqr_q <= sqr_q >> 1;
				sqb_q <= sqb_q >> 2;
				if (cnt_q == '0 && err_q < -$signed({16'd0, PiQ16}))
					err_q <= err_q + 36'(TwoPiQ16);
			end
			ST_OUT1: dist_q <= sqr_q[31:0];
			ST_OUT2: if (out_load) begin
				lin_q <= (lin_w > 48'sh7FFF_FFFF) ? 31'h7FFF_FFFF : lin_w[30:0];
				rot_q <= (rot_w > 48'sh7FFF_FFFF) ? 32'sh7FFF_FFFF
					: (rot_w < -48'sh8000_0000) ? 32'sh8000_0000 : rot_w[31:0];
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

### sim/tb_lemniscate_pursuit_controller.sv
// Testbench for the lemniscate pursuit controller: streamed poses against a bit-exact predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_lemniscate_pursuit_controller;
	import lpc_pkg::*;

	localparam logic [1:0] RegUnused = 2'd3;
	localparam int SettleCycles = 300;
	localparam int IdleLimit = 20000;
	localparam longint PiFix = 205887;
	localparam longint TwoPiFix = 411775;
	localparam longint HalfPiFix = 102944;
	localparam longint PiFix30 = 64'sd3373259426;
	localparam longint HalfPiFix30 = 1686629713;
	localparam longint OneFix30 = 1073741824;
	localparam longint CordicGain = 652032874;

	typedef struct packed {
		logic signed [18:0] heading;
		logic signed [23:0] y;
		logic signed [23:0] x;
	} pose_t;

	typedef struct packed {
		logic signed [31:0] angular;
		logic [30:0] linear;
	} cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic we = 1'b0;
	logic [1:0] idx = '0;
	logic [21:0] wdata = '0;

	lemniscate_pursuit_controller dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.we(we), .idx(idx), .wdata(wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	pose_t pose_queue[$];
	cmd_t cmd_queue[$];
	int words_in = 0;
	int words_out = 0;
	int mismatches = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_cycles = 0;
	bit hold_done = 1'b0;
	int idle_count = 0;

	// Predictor state and register copies.
	logic [21:0] size_reg;
	logic [16:0] step_reg;
	logic [9:0] gain_reg;
	logic [19:0] phase_acc;
	longint org_x, org_y;
	bit org_set;

	longint arctan[18] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
		64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF
	};

	function automatic longint root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint goal_bearing(longint ey, longint ex);
		longint base, x, y, z, t;
		base = 0;
		z = 0;
		if (ex == 0 && ey == 0)
			return 0;
		if (ex < 0) begin
			base = (ey >= 0) ? PiFix30 : -PiFix30;
			ex = -ex;
			ey = -ey;
		end
		x = ex * 65536;
		y = ey * 65536;
		for (int i = 0; i < CordicIterations; i++) begin
			if (y < 0) begin
				t = x - (y >>> i); y = y + (x >>> i); x = t; z -= arctan[i];
			end else begin
				t = x + (y >>> i); y = y - (x >>> i); x = t; z += arctan[i];
			end
		end
		return (base + z + 8192) >>> 14;
	endfunction

	function automatic cmd_t steer(pose_t p);
		longint px, py, th, ang, s, c, t, den, dx, dy, ex, ey, err, lin, rot;
		bit flip;
		logic [20:0] ph;
		cmd_t r;
		px = longint'(p.x);
		py = longint'(p.y);
		th = longint'(p.heading);
		flip = 1'b0;
		if (!org_set) begin
			org_x = px;
			org_y = py;
			org_set = 1'b1;
		end
		ph = phase_acc + step_reg;
		if (ph >= TwoPiFix)
			ph -= TwoPiFix;
		phase_acc = ph[19:0];
		ang = longint'(phase_acc);
		if (ang > PiFix)
			ang -= TwoPiFix;
		ang *= 16384;
		if (ang > HalfPiFix30) begin
			ang -= PiFix30;
			flip = 1'b1;
		end else if (ang < -HalfPiFix30) begin
			ang += PiFix30;
			flip = 1'b1;
		end
		c = CordicGain;
		s = 0;
		for (int i = 0; i < CordicIterations; i++) begin
			if (ang >= 0) begin
				t = c - (s >>> i); s = s + (c >>> i); c = t; ang -= arctan[i];
			end else begin
				t = c + (s >>> i); s = s - (c >>> i); c = t; ang += arctan[i];
			end
		end
		if (flip) begin
			s = -s;
			c = -c;
		end
		den = ((s * s) >>> 30) + OneFix30;
		dx = (longint'(size_reg) * c) / den;
		dy = (longint'(size_reg) * ((s * c) >>> 30)) / den;
		ex = org_x + dx - px;
		ey = org_y + dy - py;
		err = goal_bearing(ey, ex) - th;
		if (err > PiFix)
			err -= TwoPiFix;
		if (err < -PiFix)
			err += TwoPiFix;
		lin = root_floor(longint'(ex * ex + ey * ey)) * longint'(gain_reg);
		if (lin > 64'h7FFFFFFF)
			lin = 64'h7FFFFFFF;
		rot = err * longint'(gain_reg);
		if (rot > 64'sd2147483647)
			rot = 64'sd2147483647;
		if (rot < -64'sd2147483648)
			rot = -64'sd2147483648;
		r.linear = lin[30:0];
		r.angular = rot[31:0];
		return r;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(20, 80);
	endfunction

	// Sender: presents queued poses and runs the predictor on each accepted word.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				cmd_queue.push_back(steer(pose_t'(s_axis_tdata[66:0])));
				words_in++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0 || pose_queue.size() == 0) begin
					if (send_gap > 0)
						send_gap--;
					s_axis_tvalid <= 1'b0;
				end else begin
					s_axis_tdata <= {5'b0, pose_queue.pop_front()};
					s_axis_tvalid <= 1'b1;
					send_gap = pick_gap();
				end
			end
		end
	end

	// Receiver: checks each taken word and stalls at random, once for a long stretch.
	always @(posedge clk) begin
		cmd_t got, want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[62:0];
				words_out++;
				if (cmd_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word: linear %0d angular %0d",
							got.linear, got.angular);
				end else begin
					want = cmd_queue.pop_front();
					if (got.linear !== want.linear || got.angular !== want.angular) begin
						mismatches++;
						if (mismatches <= 10)
							$display("word %0d: linear exp %0d got %0d, angular exp %0d got %0d",
								words_out, want.linear, got.linear,
								want.angular, got.angular);
					end
				end
			end
			if (!hold_done && words_out == 120) begin
				hold_done = 1'b1;
				hold_cycles = 1500;
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_axis_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				recv_gap = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || we
				|| hold_cycles > 0)
			idle_count = 0;
		else
			idle_count++;
		if (idle_count >= IdleLimit) begin
			$display("watchdog expired with %0d words pending", cmd_queue.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] i, input logic [21:0] v);
		@(posedge clk);
		we <= 1'b1;
		idx <= i;
		wdata <= v;
		case (i)
			RegCurveSize: size_reg = v;
			RegPhaseStep: step_reg = v[16:0];
			RegRateGain: gain_reg = v[9:0];
			default: ;
		endcase
		@(posedge clk);
		we <= 1'b0;
	endtask

	task automatic drain();
		while (pose_queue.size() != 0 || s_axis_tvalid || cmd_queue.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic add_pose(input longint x, input longint y, input longint h);
		pose_t p;
		p.x = x[23:0];
		p.y = y[23:0];
		p.heading = h[18:0];
		pose_queue.push_back(p);
	endtask

	// Well-formed poses stay within 393216 of the curve origin in x and y; some span the full field range.
	task automatic add_random(input int n);
		pose_t p;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 9) < 7) begin
				p.x = 24'(org_x + $signed($urandom_range(0, 786432)) - 393216);
				p.y = 24'(org_y + $signed($urandom_range(0, 786432)) - 393216);
				p.heading = 19'($signed($urandom_range(0, 411774)) - 205887);
			end else begin
				p = 67'({$urandom, $urandom, $urandom});
			end
			pose_queue.push_back(p);
		end
	endtask

	initial begin
		size_reg = 22'd262144;
		step_reg = 17'd3277;
		gain_reg = 10'd20;
		phase_acc = HalfPiFix[19:0];
		org_x = 0;
		org_y = 0;
		org_set = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// The first pose becomes the curve origin.
		add_pose(65536, -32768, 0);
		add_pose(8388607, 8388607, 205887);
		add_pose(-8388608, -8388608, -205887);
		add_pose(8388607, -8388608, 262143);
		add_pose(-8388608, 8388607, -262144);
		add_pose(65536, -32768, 205887);
		add_pose(65536, -32768, -205887);
		add_pose(0, 0, 100000);
		add_pose(-65536, 32768, -100000);
		for (int k = 0; k < 8; k++)
			add_pose(65536 + 300000, -32768 + 10 * k, 205887 - k);
		// Saturate the pose fields as a whole: all ones and all zeros.
		add_pose(-1, -1, -1);
		add_pose(0, 0, 0);
		// Wait for the origin to latch before drawing poses around it.
		drain();
		add_random(180);
		drain();

		write_reg(RegCurveSize, 22'h3FFFFF);
		write_reg(RegPhaseStep, 22'd65536);
		write_reg(RegRateGain, 22'd1000);
		add_random(140);
		drain();

		// Zero size and gain: a pose on the origin leaves no offset at all.
		write_reg(RegCurveSize, 22'd0);
		write_reg(RegPhaseStep, 22'd0);
		write_reg(RegRateGain, 22'd0);
		add_pose(org_x, org_y, 0);
		add_pose(org_x, org_y, 205887);
		add_random(40);
		drain();
		write_reg(RegRateGain, 22'd1);
		add_pose(org_x, org_y, -205887);
		add_pose(org_x, org_y, 262143);
		drain();

		write_reg(RegCurveSize, 22'd2097152);
		write_reg(RegPhaseStep, 22'h1FFFF);
		write_reg(RegRateGain, 22'h3FF);
		add_random(140);
		drain();

		// Writes to the spare index must leave every register alone.
		write_reg(RegUnused, 22'h155555);
		write_reg(RegCurveSize, 22'd131072);
		write_reg(RegPhaseStep, 22'd3277);
		write_reg(RegRateGain, 22'd20);
		write_reg(RegUnused, 22'h2AAAAA);
		add_random(130);
		drain();

		$display("%0d poses sent and %0d commands checked over five register settings,",
			words_in, words_out);
		$display("including zero gain, the spare index and a long output stall.");
		if (mismatches == 0 && cmd_queue.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

### sim.f
src/lpc_pkg.sv
src/lemniscate_pursuit_controller.sv
sim/tb_lemniscate_pursuit_controller.sv
